// File: rtl/dq_pkg.sv
// Shared types and constants for the double-ended queue.
package dq_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CmdW  = 3;

  // Command codes; unused codes act as a query
  localparam logic [CmdW-1:0] CmdQuery     = 3'd0;
  localparam logic [CmdW-1:0] CmdPushFront = 3'd1;
  localparam logic [CmdW-1:0] CmdPushBack  = 3'd2;
  localparam logic [CmdW-1:0] CmdPopFront  = 3'd3;
  localparam logic [CmdW-1:0] CmdPopBack   = 3'd4;

  // Word reported for a missing pop or an empty end
  localparam logic [WordW-1:0] EmptyWord = '1;

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StFetch,
    StEmit
  } dq_state_e;

  // Controller to datapath
  typedef struct packed {
    logic latch;
    logic exec;
    logic fetch;
    logic emit;
  } dq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_fetch;
  } dq_stat_t;

endpackage

// File: rtl/dq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/dq_ctrl.sv
// Controller state machine sequencing one queue operation at a time.
module dq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  dq_pkg::dq_stat_t stat_i,
  output dq_pkg::dq_cmd_t  cmd_o
);
  import dq_pkg::*;

  dq_state_e state_q, state_d;
  logic      out_valid_q, out_valid_d;
  logic      slot_free;
  logic      accept;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign accept    = (state_q == StIdle) && in_valid_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StExec;
      end
      StExec: begin
        state_d = stat_i.need_fetch ? StFetch : StEmit;
      end
      StFetch: begin
        state_d = StEmit;
      end
      StEmit: begin
        if (slot_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o       = '0;
    cmd_o.latch = accept;
    cmd_o.exec  = (state_q == StExec);
    cmd_o.fetch = (state_q == StFetch);
    cmd_o.emit  = (state_q == StEmit) && slot_free;
  end

  // Hold the result beat until taken
  assign out_valid_d = cmd_o.emit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/dq_dp.sv
// Datapath: ring pointers, count, cached end words, entry RAM and result register.
module dq_dp #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dq_pkg::dq_cmd_t          cmd_i,
  output dq_pkg::dq_stat_t         stat_o,
  input  logic [dq_pkg::CmdW-1:0]  cmd_in_i,
  input  logic signed [dq_pkg::WordW-1:0] push_value_i,
  output logic signed [dq_pkg::WordW-1:0] popped_value_o,
  output logic [CntW-1:0]          entry_count_o,
  output logic                     is_empty_o,
  output logic signed [dq_pkg::WordW-1:0] front_value_o,
  output logic signed [dq_pkg::WordW-1:0] back_value_o,
  output logic                     push_dropped_o
);
  import dq_pkg::*;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  function automatic logic [IdxW-1:0] slot_next(input logic [IdxW-1:0] s);
    return (s == LastIdx) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] slot_prev(input logic [IdxW-1:0] s);
    return (s == '0) ? LastIdx : s - 1'b1;
  endfunction

  logic [CmdW-1:0]  op_q;
  logic [WordW-1:0] val_q;
  logic [IdxW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [WordW-1:0] front_q, front_d, back_q, back_d;
  logic [WordW-1:0] popped_q, popped_d;
  logic             dropped_q, dropped_d;
  logic             need_fetch;

  logic             ram_we, ram_re;
  logic [IdxW-1:0]  ram_waddr, ram_raddr;
  logic [WordW-1:0] ram_rdata;

  logic [WordW-1:0] res_popped_q, res_front_q, res_back_q;
  logic [CntW-1:0]  res_count_q;
  logic             res_dropped_q;

  // Capture the input beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= cmd_in_i;
      val_q <= push_value_i;
    end
  end

  // Apply the operation and pick the refill read
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    front_d    = front_q;
    back_d     = back_q;
    popped_d   = popped_q;
    dropped_d  = dropped_q;
    ram_we     = 1'b0;
    ram_waddr  = tail_q;
    ram_re     = 1'b0;
    ram_raddr  = slot_next(head_q);
    need_fetch = 1'b0;
    if (cmd_i.exec) begin
      popped_d  = EmptyWord;
      dropped_d = 1'b0;
      unique case (op_q)
        CmdPushFront: begin
          if (count_q == FullCnt) begin
            dropped_d = 1'b1;
          end else begin
            head_d    = slot_prev(head_q);
            ram_we    = 1'b1;
            ram_waddr = slot_prev(head_q);
            front_d   = val_q;
            if (count_q == '0) back_d = val_q;
            count_d   = count_q + 1'b1;
          end
        end
        CmdPushBack: begin
          if (count_q == FullCnt) begin
            dropped_d = 1'b1;
          end else begin
            tail_d    = slot_next(tail_q);
            ram_we    = 1'b1;
            ram_waddr = tail_q;
            back_d    = val_q;
            if (count_q == '0) front_d = val_q;
            count_d   = count_q + 1'b1;
          end
        end
        CmdPopFront: begin
          if (count_q != '0) begin
            popped_d   = front_q;
            head_d     = slot_next(head_q);
            count_d    = count_q - 1'b1;
            need_fetch = (count_q != CntW'(1));
            ram_re     = need_fetch;
            ram_raddr  = slot_next(head_q);
          end
        end
        CmdPopBack: begin
          if (count_q != '0) begin
            popped_d   = back_q;
            tail_d     = slot_prev(tail_q);
            count_d    = count_q - 1'b1;
            need_fetch = (count_q != CntW'(1));
            ram_re     = need_fetch;
            ram_raddr  = slot_prev(slot_prev(tail_q));
          end
        end
        default: ;
      endcase
    end
    // Refill the end that was popped
    if (cmd_i.fetch) begin
      if (op_q == CmdPopFront) begin
        front_d = ram_rdata;
      end else begin
        back_d = ram_rdata;
      end
    end
  end

  assign stat_o.need_fetch = need_fetch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q   <= front_d;
    back_q    <= back_d;
    popped_q  <= popped_d;
    dropped_q <= dropped_d;
  end

  dq_ram #(
    .Width(WordW),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(val_q),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Load the result beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_popped_q  <= popped_q;
      res_count_q   <= count_q;
      res_front_q   <= (count_q == '0) ? EmptyWord : front_q;
      res_back_q    <= (count_q == '0) ? EmptyWord : back_q;
      res_dropped_q <= dropped_q;
    end
  end

  assign popped_value_o = res_popped_q;
  assign entry_count_o  = res_count_q;
  assign is_empty_o     = (res_count_q == '0);
  assign front_value_o  = res_front_q;
  assign back_value_o   = res_back_q;
  assign push_dropped_o = res_dropped_q;

endmodule

// File: rtl/double_ended_queue_top.sv
// Top level of the double-ended queue over a ring buffer of DEPTH words.
//
//   channel  direction  handshake               fields
//   in       input      in_valid_i/in_stall_o   cmd_i, push_value_i
//   out      output     out_valid_o/out_stall_i popped_value_o, entry_count_o,
//                                               is_empty_o, front_value_o,
//                                               back_value_o, push_dropped_o
//
// An item occupies the sequencer, which takes no new item, through its steps:
// accept, execute, the RAM read that refills the popped end (only for a pop that
// leaves the queue non-empty), emit. The result beat is loaded in the emit step,
// and the next beat is accepted in the cycle after the result is loaded.
// Reset clears pointers and count; the entry RAM needs no clearing.
// A stalled result holds the sequencer in its emit step.
module double_ended_queue_top #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [dq_pkg::CmdW-1:0]         cmd_i,
  input  logic signed [dq_pkg::WordW-1:0] push_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [dq_pkg::WordW-1:0] popped_value_o,
  output logic [CntW-1:0]                 entry_count_o,
  output logic                            is_empty_o,
  output logic signed [dq_pkg::WordW-1:0] front_value_o,
  output logic signed [dq_pkg::WordW-1:0] back_value_o,
  output logic                            push_dropped_o
);
  import dq_pkg::*;

  dq_cmd_t  cmd;
  dq_stat_t stat;

  dq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dq_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cmd_in_i      (cmd_i),
    .push_value_i  (push_value_i),
    .popped_value_o(popped_value_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o),
    .push_dropped_o(push_dropped_o)
  );

endmodule
